[rtl/sljx_pkg.sv]
// ----------------------------------------------------------------------------
// sljx_pkg: shared types and constants of the sync/length/id frame parser
// Holds the parser state codes, status codes, register indexes and the
// result record passed from the parser core to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package sljx_pkg;

    // Received byte width
    localparam int BYTE_W     = 8;
    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_FIRST  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_SECOND = 1'd1;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

    // Parser state codes
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SYNC1     = 3'd1;
    localparam logic [2:0] ST_SYNC2     = 3'd2;
    localparam logic [2:0] ST_LENGTH    = 3'd3;
    localparam logic [2:0] ST_ID        = 3'd4;
    localparam logic [2:0] ST_PAYLOAD   = 3'd5;
    localparam logic [2:0] ST_CHECK_OK  = 3'd6;
    localparam logic [2:0] ST_CHECK_BAD = 3'd7;

    // Frame status codes
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd0;
    localparam logic [1:0] STATUS_GOOD       = 2'd1;
    localparam logic [1:0] STATUS_BAD        = 2'd2;

    // Output stream widths
    localparam int TDATA_FIELD_W = 45;
    localparam int TDATA_W       = 48;

    typedef struct packed {
        logic [1:0] frame_status;
        logic [2:0] parser_state;
        logic [7:0] payload_index;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_position;
        logic [7:0] message_id;
        logic [7:0] message_length;
    } sljx_result_t;

endpackage

`default_nettype wire

[rtl/sljx_parse_core.sv]
// ----------------------------------------------------------------------------
// sljx_parse_core: frame parser state and next-state logic
// Holds the sync registers and the frame state, and computes one result
// per byte from the registered input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sljx_parse_core
    import sljx_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  step_en,
    input  wire logic [BYTE_W-1:0]     rx_byte,
    output sljx_result_t               result
);

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic [2:0] state_reg,  state_next;
    logic [7:0] len_reg,    len_next;
    logic [7:0] count_reg,  count_next;
    logic [7:0] id_reg,     id_next;
    logic [7:0] xor_reg,    xor_next;
    logic [1:0] status;
    logic       pvalid;
    logic [7:0] pbyte;
    logic [7:0] ppos;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata;
                REG_SYNC_SECOND: sync_second_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Compute next frame state and the result of this byte
    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        count_next = count_reg;
        id_next    = id_reg;
        xor_next   = xor_reg;
        status     = STATUS_INCOMPLETE;
        pvalid     = 1'b0;
        pbyte      = 8'd0;
        ppos       = 8'd0;
        unique case (state_reg)
            ST_IDLE: begin
                if (rx_byte == sync_first_reg) state_next = ST_SYNC1;
            end
            ST_SYNC1: begin
                if (rx_byte == sync_second_reg) begin
                    len_next   = 8'd0;
                    state_next = ST_SYNC2;
                end
            end
            ST_SYNC2: begin
                len_next   = rx_byte;
                count_next = 8'd0;
                xor_next   = rx_byte;
                state_next = ST_LENGTH;
            end
            ST_LENGTH: begin
                id_next    = rx_byte;
                xor_next   = xor_reg ^ rx_byte;
                state_next = (len_reg == 8'd0) ? ST_PAYLOAD : ST_ID;
            end
            ST_ID: begin
                pvalid     = 1'b1;
                pbyte      = rx_byte;
                ppos       = count_reg;
                count_next = count_reg + 8'd1;
                xor_next   = xor_reg ^ rx_byte;
                if (count_next == len_reg) state_next = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                state_next = (rx_byte == xor_reg) ? ST_CHECK_OK : ST_CHECK_BAD;
            end
            ST_CHECK_OK: begin
                status     = STATUS_GOOD;
                state_next = ST_IDLE;
            end
            ST_CHECK_BAD: begin
                status     = STATUS_BAD;
                state_next = (rx_byte == sync_first_reg) ? ST_SYNC1 : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Advance frame state on each consumed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
            id_reg    <= 8'd0;
            xor_reg   <= 8'd0;
        end else if (step_en) begin
            state_reg <= state_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            id_reg    <= id_next;
            xor_reg   <= xor_next;
        end
    end

    // Pack the result
    always_comb begin
        result.frame_status     = status;
        result.parser_state     = state_next;
        result.payload_index    = count_next;
        result.payload_valid    = pvalid;
        result.payload_byte     = pbyte;
        result.payload_position = ppos;
        result.message_id       = id_next;
        result.message_length   = len_next;
    end

    a_report_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && state_reg == ST_CHECK_OK) |=> state_reg == ST_IDLE)
        else $error("good-frame report did not return to idle");

    a_status_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && status != STATUS_INCOMPLETE)
        |=> (state_reg == ST_IDLE || state_reg == ST_SYNC1))
        else $error("frame report left parser inside a frame");

    a_length_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && state_reg == ST_SYNC2) |=> count_reg == 8'd0)
        else $error("payload count not cleared on length byte");

endmodule

`default_nettype wire

[rtl/sljx_out_stage.sv]
// ----------------------------------------------------------------------------
// sljx_out_stage: result register with skid entry
// Holds finished results for the master side and keeps accepting while
// one result waits, so a stall costs no throughput.
// ----------------------------------------------------------------------------
`default_nettype none

module sljx_out_stage
    import sljx_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire sljx_result_t push_data,
    output logic        push_ready,
    output logic        out_valid,
    input  wire logic   out_ready,
    output sljx_result_t out_data
);

    logic         main_valid_reg;
    sljx_result_t main_data_reg;
    logic         skid_valid_reg;
    sljx_result_t skid_data_reg;
    logic         pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_data_reg;

    // Control: main slot and skid slot occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) skid_valid_reg <= 1'b0;
        end else if (push) begin
            if (main_valid_reg && !pop) skid_valid_reg <= 1'b1;
            main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload: load main from skid or input, park in skid on stall
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) main_data_reg <= skid_data_reg;
        end else if (push) begin
            if (!main_valid_reg || pop) main_data_reg <= push_data;
            else                        skid_data_reg <= push_data;
        end
    end

    a_skid_implies_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty main slot");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && pop) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to main slot");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !push)
        else $error("item pushed while both slots full");

endmodule

`default_nettype wire

[rtl/sync_len_id_xor_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// sync_len_id_xor_frame_parser_unit: two-sync-byte frame parser
// Parses sync 1, sync 2, length, id, payload and XOR check byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one received byte per item (s_tdata[7:0]). Master side
//   gives exactly one result item per byte: status, parser state, payload
//   count and position, payload byte, message id and length.
//   m_tuser flags an item that carries a payload byte; downstream buffers
//   those and commits them when a good status arrives.
//   Sync byte values are written through cfg_we/cfg_addr/cfg_wdata
//   (index 0 first sync byte, index 1 second); the user must write them only
//   while no item is in flight, as the block itself does not enforce it.
// Path: an accepted byte enters the input register; from there the parser
//   state updates and its result goes into the result register (or skid).
// Throughput: one item per cycle while the output stage accepts results.
// Reset: state returns to idle, counters clear, sync bytes become 0xAA and
//   0x55, both stream registers empty.
// Stall: a skid entry behind the result register absorbs one result and the
//   input register one more byte, then s_tready drops until the master side
//   drains; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_len_id_xor_frame_parser_unit
    import sljx_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // slave side
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
    // master side
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [1:0] frame_status, [4:2] parser_state, [12:5] payload_index,
    // [20:13] payload_byte, [28:21] payload_position, [36:29] message_id,
    // [44:37] message_length, [47:45] zero
    output logic [TDATA_W-1:0]         m_tdata,
    output logic                       m_tuser    // [0] payload_valid
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              push_ready;
    logic              advance;
    sljx_result_t      core_result;
    sljx_result_t      out_data;

    assign advance  = in_valid_reg && push_ready;
    assign s_tready = !in_valid_reg || push_ready;

    // Input register: hold the byte until the parser consumes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) in_byte_reg <= s_tdata;
    end

    sljx_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step_en   (advance),
        .rx_byte   (in_byte_reg),
        .result    (core_result)
    );

    sljx_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (advance),
        .push_data  (core_result),
        .push_ready (push_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    // Pack the result item
    assign m_tdata = {{(TDATA_W - TDATA_FIELD_W){1'b0}},
                      out_data.message_length,
                      out_data.message_id,
                      out_data.payload_position,
                      out_data.payload_byte,
                      out_data.payload_index,
                      out_data.parser_state,
                      out_data.frame_status};
    assign m_tuser = out_data.payload_valid;

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-sync-byte frame parser
// Feeds received bytes on the slave stream and predicts, byte by byte, the
// parser state, payload emission, id, length and good/bad status. Every
// result item on the master stream is checked against the oldest prediction.
// Covers directed frames, several sync byte settings, long random frame
// streams, back-pressure and raw byte noise.
// ----------------------------------------------------------------------------

module tb_top;
    import sljx_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;

    // Parser mirror: configuration and frame state
    logic [7:0] pr_sync1 = SYNC_FIRST_RST;
    logic [7:0] pr_sync2 = SYNC_SECOND_RST;
    logic [2:0] pr_state = ST_IDLE;
    logic [7:0] pr_len   = '0;
    logic [7:0] pr_count = '0;
    logic [7:0] pr_id    = '0;
    logic [7:0] pr_xor   = '0;

    sljx_result_t pending_results[$];
    sljx_result_t want_rec;
    int           mismatch_count  = 0;
    int           items_sent      = 0;
    int           tx_idle_pct     = 0;
    int           rx_stall_pct    = 0;
    int           hold_off_cycles = 0;

    sync_len_id_xor_frame_parser_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the stream hangs
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Advance the parser mirror by one byte and return the result it gives
    function automatic sljx_result_t advance_parser(input logic [7:0] b);
        sljx_result_t r;
        r = '0;
        r.frame_status = STATUS_INCOMPLETE;
        case (pr_state)
            ST_IDLE: begin
                if (b == pr_sync1) pr_state = ST_SYNC1;
            end
            ST_SYNC1: begin
                if (b == pr_sync2) begin
                    pr_len   = '0;
                    pr_state = ST_SYNC2;
                end
            end
            ST_SYNC2: begin
                pr_len   = b;
                pr_count = '0;
                pr_xor   = b;
                pr_state = ST_LENGTH;
            end
            ST_LENGTH: begin
                pr_id    = b;
                pr_xor   = pr_xor ^ b;
                pr_state = (pr_len == 8'd0) ? ST_PAYLOAD : ST_ID;
            end
            ST_ID: begin
                r.payload_valid    = 1'b1;
                r.payload_byte     = b;
                r.payload_position = pr_count;
                pr_count = pr_count + 8'd1;
                pr_xor   = pr_xor ^ b;
                if (pr_count == pr_len) pr_state = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                pr_state = (b == pr_xor) ? ST_CHECK_OK : ST_CHECK_BAD;
            end
            ST_CHECK_OK: begin
                r.frame_status = STATUS_GOOD;
                pr_state = ST_IDLE;
            end
            default: begin
                r.frame_status = STATUS_BAD;
                pr_state = (b == pr_sync1) ? ST_SYNC1 : ST_IDLE;
            end
        endcase
        r.parser_state   = pr_state;
        r.payload_index  = pr_count;
        r.message_id     = pr_id;
        r.message_length = pr_len;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each accepted result item with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result item with nothing predicted, expected none, actual %0h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want_rec = pending_results.pop_front();
                check_field("frame_status",     want_rec.frame_status,     m_tdata[1:0]);
                check_field("parser_state",     want_rec.parser_state,     m_tdata[4:2]);
                check_field("payload_index",    want_rec.payload_index,    m_tdata[12:5]);
                check_field("payload_byte",     want_rec.payload_byte,     m_tdata[20:13]);
                check_field("payload_position", want_rec.payload_position, m_tdata[28:21]);
                check_field("message_id",       want_rec.message_id,       m_tdata[36:29]);
                check_field("message_length",   want_rec.message_length,   m_tdata[44:37]);
                check_field("tdata padding",    0,                         m_tdata[47:45]);
                check_field("payload_valid",    want_rec.payload_valid,    m_tuser);
            end
        end
    end

    // Result sink: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                stall = pick_gap();
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one byte, wait for the handshake, then predict its result
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = pick_gap();
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(advance_parser(b));
        items_sent++;
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Write one sync register; call only after drain_results
    task automatic set_register(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_SYNC_FIRST) begin
            pr_sync1 = val;
        end else begin
            pr_sync2 = val;
        end
    endtask

    // Send a whole frame; skip the first sync byte if the parser already holds it
    task automatic send_frame(input logic [7:0] len, input bit bad_check,
                              input int wait_noise, input bit report_is_sync);
        logic [7:0] chk;
        logic [7:0] b;
        if (pr_state != ST_SYNC1) send_byte(pr_sync1);
        repeat (wait_noise) begin
            b = 8'($urandom);
            if (b == pr_sync2) b = b + 8'd1;
            send_byte(b);
        end
        send_byte(pr_sync2);
        send_byte(len);
        b = 8'($urandom);
        chk = len ^ b;
        send_byte(b);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            chk = chk ^ b;
            send_byte(b);
        end
        if (bad_check) chk = chk ^ (8'd1 << $urandom_range(0, 7));
        send_byte(chk);
        b = report_is_sync ? pr_sync1 : 8'($urandom);
        send_byte(b);
    endtask

    task automatic send_random_frame();
        int         r;
        logic [7:0] len;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            len = 8'($urandom_range(0, 6));
        end else if (r < 99) begin
            len = 8'($urandom_range(7, 40));
        end else begin
            len = 8'($urandom_range(128, 255));
        end
        send_frame(len, $urandom_range(0, 99) < 15,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
                   $urandom_range(0, 99) < 30);
    endtask

    // Hand-built frames at reset sync values
    task automatic test_directed_frames();
        tx_idle_pct  = 20;
        rx_stall_pct = 20;
        // noise while idle
        send_byte(8'h00);
        send_byte(8'hFF);
        // wait for sync 2 across foreign bytes; zero length; good report byte
        // equal to the first sync value must not start a frame
        send_byte(SYNC_FIRST_RST);
        send_byte(8'h13);
        send_byte(SYNC_FIRST_RST);
        send_byte(SYNC_SECOND_RST);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST_RST);
        // bad check; report byte equal to sync 1 reopens a frame
        send_byte(SYNC_FIRST_RST);
        send_byte(SYNC_SECOND_RST);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7C);
        send_byte(SYNC_FIRST_RST);
        // continue from sync 1 with a good one-byte frame
        send_byte(SYNC_SECOND_RST);
        send_byte(8'h01);
        send_byte(8'h07);
        send_byte(8'h00);
        send_byte(8'h06);
        send_byte(8'h00);
        drain_results();
    endtask

    // Random frames under several sync byte settings, extremes included
    task automatic test_sync_settings();
        logic [7:0] first_vals  [0:3];
        logic [7:0] second_vals [0:3];
        int         stop_at;
        first_vals  = '{8'h00, 8'hFF, 8'h5A, 8'hFF};
        second_vals = '{8'hFF, 8'h00, 8'h5A, 8'hFF};
        for (int k = 0; k < 4; k++) begin
            drain_results();
            set_register(REG_SYNC_FIRST, first_vals[k]);
            set_register(REG_SYNC_SECOND, second_vals[k]);
            stop_at = items_sent + 70;
            while (items_sent < stop_at) send_random_frame();
        end
        // change sync 2 while the parser holds sync 1
        drain_results();
        set_register(REG_SYNC_FIRST, SYNC_FIRST_RST);
        set_register(REG_SYNC_SECOND, SYNC_SECOND_RST);
        if (pr_state != ST_SYNC1) send_byte(pr_sync1);
        drain_results();
        set_register(REG_SYNC_SECOND, 8'hC3);
        send_frame(8'd3, 1'b0, 1, 1'b0);
        drain_results();
        set_register(REG_SYNC_SECOND, SYNC_SECOND_RST);
    endtask

    // Long stream of mostly well-formed frames with varying idle patterns
    task automatic test_random_frames();
        int stop_at;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_frame(8'd255, 1'b0, 0, 1'b0);
        stop_at = items_sent + 950;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        tx_idle_pct  = 0;
                        rx_stall_pct = 0;
                    end
                    1: begin
                        tx_idle_pct  = 20;
                        rx_stall_pct = 0;
                    end
                    2: begin
                        tx_idle_pct  = 0;
                        rx_stall_pct = 30;
                    end
                    default: begin
                        tx_idle_pct  = 25;
                        rx_stall_pct = 25;
                    end
                endcase
            end
            send_random_frame();
        end
        drain_results();
    endtask

    // Hold the result side so the input stalls, then pause the sender
    task automatic test_backpressure();
        int stop_at;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        hold_off_cycles = 80;
        stop_at = items_sent + 60;
        while (items_sent < stop_at) send_random_frame();
        drain_results();
        tx_idle_pct  = 20;
        rx_stall_pct = 20;
        stop_at = items_sent + 60;
        while (items_sent < stop_at) send_random_frame();
        drain_results();
    endtask

    // Raw bytes, biased toward the sync values
    task automatic test_byte_noise();
        int r;
        tx_idle_pct  = 15;
        rx_stall_pct = 15;
        repeat (200) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
                send_byte(pr_sync1);
            end else if (r < 4) begin
                send_byte(pr_sync2);
            end else begin
                send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_frames();
        test_sync_settings();
        test_random_frames();
        test_backpressure();
        test_byte_noise();

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sync_len_id_xor_frame_parser_unit.f]
rtl/sljx_pkg.sv
rtl/sljx_parse_core.sv
rtl/sljx_out_stage.sv
rtl/sync_len_id_xor_frame_parser_unit.sv
test/tb_top.sv
